>>> hdl/ufcc_pkg.sv
// Package for the union-find connect-count unit.
// Holds the sequencer state type, register indexes and the multiply request/response types.
// No dependencies.
`timescale 1ns / 1ps

package ufcc_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_MODULUS    = 1'b1;

  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_TOP = 4'd15;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FA_REQ,
    ST_FA_CHK,
    ST_FB_REQ,
    ST_FB_CHK,
    ST_LINK,
    ST_T_REQ,
    ST_T_CHK,
    ST_P_REQ,
    ST_P_CHK,
    ST_P_MUL,
    ST_E_CHK,
    ST_E_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] mcand;
    logic [32:0] modv;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] value;
  } mul_rsp_t;

endpackage

>>> hdl/ufcc_mulmod.sv
// Shared modular multiplier: mcand * mplier mod modv, double-and-add from the MSB.
// Depends on ufcc_pkg for the request/response types.
`timescale 1ns / 1ps

module ufcc_mulmod #(
  parameter int BW = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ufcc_pkg::mul_req_t  req_i,
  input  logic [BW-1:0]       mplier_i,
  output ufcc_pkg::mul_rsp_t  rsp_o
);

  localparam int CNTW = $clog2(BW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            phase_q, phase_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [31:0]     r_q, r_d;
  logic [31:0]     a_q, a_d;
  logic [32:0]     m_q, m_d;
  logic [BW-1:0]   b_q, b_d;
  logic [32:0]     dbl;
  logic [32:0]     sum;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    r_d     = r_q;
    a_d     = a_q;
    m_d     = m_q;
    b_d     = b_q;
    dbl     = {r_q, 1'b0};
    sum     = {1'b0, r_q} + (b_q[BW-1] ? {1'b0, a_q} : 33'd0);
    if (req_i.start && !busy_q) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = CNTW'(BW - 1);
      r_d     = 32'd0;
      a_d     = req_i.mcand;
      m_d     = req_i.modv;
      b_d     = mplier_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        // double the partial result
        if (dbl >= m_q) begin
          dbl = dbl - m_q;
        end
        r_d     = dbl[31:0];
        phase_d = 1'b1;
      end else begin
        // add the multiplicand when the current bit is set
        if (sum >= m_q) begin
          sum = sum - m_q;
        end
        r_d     = sum[31:0];
        b_d     = {b_q[BW-2:0], 1'b0};
        phase_d = 1'b0;
        if (cnt_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    m_q <= m_d;
    b_q <= b_d;
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done_q;
  assign rsp_o.value = r_q;

endmodule

>>> hdl/union_find_connect_count_unit.sv
// Top level of the union-find connect-count unit: forest memories and sequencer.
// Depends on ufcc_pkg and instantiates ufcc_mulmod.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i/in_ready_o): opcode 0 transfers an edge (end_a_i, end_b_i,
//   one-based); opcode 1 transfers a finish. Edges give no result. A finish gives one
//   transfer on the output channel (out_valid_o/out_ready_i): answer_o and components_o.
//   An edge walks the parent chain from each endpoint, then links the two roots;
//   chains stay short since union by rank bounds tree depth near log2(nodes).
//   A finish walks every node in use twice; the shared bit-serial modular multiplier
//   (NW multiplier bits) runs once per component on the second walk, then once per
//   extra power of node_count. The forest memories have a registered read port, so
//   every walk step is a read followed by a check.
//   Reset, and the end of every finish, run a clearing pass over all MAX_NODES memory
//   entries; in_ready_o stays low meanwhile. Configuration writes are taken at all times.
//   The result sits in an output register; a stalled receiver holds the block in its
//   last finish step until the slot frees, and the next item waits behind it.
//   Configuration: APB-style, node_count at 0x0, modulus at 0x4; pready is always high.
module union_find_connect_count_unit #(
  parameter int MAX_NODES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [10:0] end_a_i,
  input  logic [10:0] end_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] answer_o,
  output logic [10:0] components_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW = AW + 1;
  localparam int CW = (NW > 11) ? NW : 11;
  localparam int RW = ufcc_pkg::RANK_W;

  // Forest storage.
  logic [AW-1:0] parent_mem [MAX_NODES];
  logic [RW-1:0] rank_mem   [MAX_NODES];
  logic [NW-1:0] size_mem   [MAX_NODES];

  ufcc_pkg::state_e state_q, state_d;

  logic [10:0]   node_count_q;
  logic [31:0]   modulus_q;
  logic [AW-1:0] x_q, xb_q, ra_q, rb_q;
  logic [RW-1:0] rka_q, rkb_q;
  logic [NW-1:0] i_q, k_q, j_q, n_q;
  logic [31:0]   acc_q;
  logic          out_valid_q;
  logic [31:0]   answer_q;
  logic [10:0]   comps_q;

  logic [AW-1:0] par_rd_q;
  logic [RW-1:0] rank_rd_q;
  logic [NW-1:0] size_rd_q;

  // Memory and multiplier control from the output decoder.
  logic [AW-1:0] rd_addr;
  logic          par_we, rank_we, size_we;
  logic [AW-1:0] par_wa, rank_wa, size_wa;
  logic [AW-1:0] par_wd;
  logic [RW-1:0] rank_wd;
  logic [NW-1:0] size_wd;
  logic          load_out;

  ufcc_pkg::mul_req_t mul_req;
  ufcc_pkg::mul_rsp_t mul_rsp;
  logic [NW-1:0]      mul_b;

  logic          accept;
  logic [NW-1:0] n_eff;
  logic          ends_ok;
  logic [CW-1:0] a_w, b_w, a_m1, b_m1;
  logic [32:0]   modv;
  logic [31:0]   one_mod;
  logic          is_root;
  logic [NW-1:0] i_inc;
  logic          i_last;
  logic          clear_last;
  logic          cfg_we;

  // ---------------------------------------------------------------- configuration
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      ufcc_pkg::REG_NODE_COUNT: prdata = {21'd0, node_count_q};
      ufcc_pkg::REG_MODULUS:    prdata = modulus_q;
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 11'd1024;
      modulus_q    <= 32'd1000000007;
    end else if (cfg_we) begin
      case (paddr[2])
        ufcc_pkg::REG_NODE_COUNT: node_count_q <= pwdata[10:0];
        ufcc_pkg::REG_MODULUS:    modulus_q    <= pwdata;
        default:                  ;
      endcase
    end
  end

  // ---------------------------------------------------------------- derived values
  // A zero modulus stands for 2^32.
  assign modv    = (modulus_q == 32'd0) ? {1'b1, 32'd0} : {1'b0, modulus_q};
  assign one_mod = (modulus_q == 32'd1) ? 32'd0 : 32'd1;

  // Clamp node_count to the forest size.
  assign n_eff = (CW'(node_count_q) > CW'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(node_count_q);

  assign a_w     = CW'(end_a_i);
  assign b_w     = CW'(end_b_i);
  assign a_m1    = a_w - CW'(1);
  assign b_m1    = b_w - CW'(1);
  assign ends_ok = (a_w != '0) && (b_w != '0) &&
                   (a_w <= CW'(n_eff)) && (b_w <= CW'(n_eff));

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ufcc_pkg::ST_IDLE);

  assign is_root    = (par_rd_q == x_q);
  assign i_inc      = i_q + 1'b1;
  assign i_last     = (i_inc == n_q);
  assign clear_last = (i_q == NW'(MAX_NODES - 1));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ufcc_pkg::ST_CLEAR: if (clear_last) state_d = ufcc_pkg::ST_IDLE;
      ufcc_pkg::ST_IDLE: begin
        if (accept) begin
          if (!opcode_i) begin
            state_d = ends_ok ? ufcc_pkg::ST_FA_REQ : ufcc_pkg::ST_IDLE;
          end else begin
            state_d = (n_eff == '0) ? ufcc_pkg::ST_E_CHK : ufcc_pkg::ST_T_REQ;
          end
        end
      end
      ufcc_pkg::ST_FA_REQ: state_d = ufcc_pkg::ST_FA_CHK;
      ufcc_pkg::ST_FA_CHK: state_d = is_root ? ufcc_pkg::ST_FB_REQ : ufcc_pkg::ST_FA_REQ;
      ufcc_pkg::ST_FB_REQ: state_d = ufcc_pkg::ST_FB_CHK;
      ufcc_pkg::ST_FB_CHK: state_d = is_root ? ufcc_pkg::ST_LINK : ufcc_pkg::ST_FB_REQ;
      ufcc_pkg::ST_LINK:   state_d = ufcc_pkg::ST_IDLE;
      ufcc_pkg::ST_T_REQ:  state_d = ufcc_pkg::ST_T_CHK;
      ufcc_pkg::ST_T_CHK: begin
        if (is_root && i_last) state_d = ufcc_pkg::ST_P_REQ;
        else                   state_d = ufcc_pkg::ST_T_REQ;
      end
      ufcc_pkg::ST_P_REQ: state_d = ufcc_pkg::ST_P_CHK;
      ufcc_pkg::ST_P_CHK: begin
        if (par_rd_q == i_q[AW-1:0]) state_d = ufcc_pkg::ST_P_MUL;
        else if (i_last)             state_d = ufcc_pkg::ST_E_CHK;
        else                         state_d = ufcc_pkg::ST_P_REQ;
      end
      ufcc_pkg::ST_P_MUL: begin
        if (mul_rsp.done) state_d = i_last ? ufcc_pkg::ST_E_CHK : ufcc_pkg::ST_P_REQ;
      end
      ufcc_pkg::ST_E_CHK: begin
        state_d = (k_q != NW'(1) && j_q < k_q) ? ufcc_pkg::ST_E_MUL : ufcc_pkg::ST_DONE;
      end
      ufcc_pkg::ST_E_MUL: if (mul_rsp.done) state_d = ufcc_pkg::ST_E_CHK;
      ufcc_pkg::ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ufcc_pkg::ST_CLEAR;
      default:            state_d = ufcc_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- outputs of the sequencer
  always_comb begin
    rd_addr  = x_q;
    par_we   = 1'b0;
    rank_we  = 1'b0;
    size_we  = 1'b0;
    par_wa   = x_q;
    rank_wa  = x_q;
    size_wa  = x_q;
    par_wd   = x_q;
    rank_wd  = '0;
    size_wd  = size_rd_q + 1'b1;
    load_out = 1'b0;
    mul_req.start = 1'b0;
    mul_req.mcand = acc_q;
    mul_req.modv  = modv;
    mul_b         = n_q;
    case (state_q)
      ufcc_pkg::ST_CLEAR: begin
        // reset every entry to a singleton
        par_we  = 1'b1;
        rank_we = 1'b1;
        size_we = 1'b1;
        par_wa  = i_q[AW-1:0];
        rank_wa = i_q[AW-1:0];
        size_wa = i_q[AW-1:0];
        par_wd  = i_q[AW-1:0];
        size_wd = '0;
      end
      ufcc_pkg::ST_LINK: begin
        if (ra_q != rb_q) begin
          par_we = 1'b1;
          if (rka_q >= rkb_q) begin
            par_wa = rb_q;
            par_wd = ra_q;
            if (rka_q == rkb_q && rka_q < ufcc_pkg::RANK_TOP) begin
              rank_we = 1'b1;
              rank_wa = ra_q;
              rank_wd = rka_q + 1'b1;
            end
          end else begin
            par_wa = ra_q;
            par_wd = rb_q;
          end
        end
      end
      ufcc_pkg::ST_T_CHK: begin
        // bump the size tally of the root just reached
        size_we = is_root;
      end
      ufcc_pkg::ST_P_REQ: rd_addr = i_q[AW-1:0];
      ufcc_pkg::ST_P_CHK: begin
        mul_req.start = (par_rd_q == i_q[AW-1:0]);
        mul_b         = size_rd_q;
      end
      ufcc_pkg::ST_E_CHK: mul_req.start = (k_q != NW'(1) && j_q < k_q);
      ufcc_pkg::ST_DONE:  load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (par_we)  parent_mem[par_wa] <= par_wd;
    if (rank_we) rank_mem[rank_wa]  <= rank_wd;
    if (size_we) size_mem[size_wa]  <= size_wd;
    par_rd_q  <= parent_mem[rd_addr];
    rank_rd_q <= rank_mem[rd_addr];
    size_rd_q <= size_mem[rd_addr];
  end

  ufcc_mulmod #(
    .BW (NW)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mul_req),
    .mplier_i (mul_b),
    .rsp_o    (mul_rsp)
  );

  // ---------------------------------------------------------------- state and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ufcc_pkg::ST_CLEAR;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ufcc_pkg::ST_CLEAR: i_q <= i_q + 1'b1;
        ufcc_pkg::ST_IDLE:  i_q <= '0;
        ufcc_pkg::ST_T_CHK: begin
          if (is_root) i_q <= i_last ? '0 : i_inc;
        end
        ufcc_pkg::ST_P_CHK: begin
          if (par_rd_q != i_q[AW-1:0]) i_q <= i_inc;
        end
        ufcc_pkg::ST_P_MUL: if (mul_rsp.done) i_q <= i_inc;
        ufcc_pkg::ST_DONE:  i_q <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      answer_q <= acc_q;
      comps_q  <= 11'(k_q);
    end
    case (state_q)
      ufcc_pkg::ST_IDLE: begin
        if (accept) begin
          x_q   <= opcode_i ? '0 : a_m1[AW-1:0];
          xb_q  <= b_m1[AW-1:0];
          n_q   <= n_eff;
          k_q   <= '0;
          j_q   <= NW'(2);
          acc_q <= one_mod;
        end
      end
      ufcc_pkg::ST_FA_CHK: begin
        if (is_root) begin
          ra_q  <= x_q;
          rka_q <= rank_rd_q;
          x_q   <= xb_q;
        end else begin
          x_q <= par_rd_q;
        end
      end
      ufcc_pkg::ST_FB_CHK: begin
        if (is_root) begin
          rb_q  <= x_q;
          rkb_q <= rank_rd_q;
        end else begin
          x_q <= par_rd_q;
        end
      end
      ufcc_pkg::ST_T_CHK: x_q <= is_root ? i_inc[AW-1:0] : par_rd_q;
      ufcc_pkg::ST_P_CHK: if (par_rd_q == i_q[AW-1:0]) k_q <= k_q + 1'b1;
      ufcc_pkg::ST_P_MUL: if (mul_rsp.done) acc_q <= mul_rsp.value;
      ufcc_pkg::ST_E_CHK: if (k_q == NW'(1)) acc_q <= one_mod;
      ufcc_pkg::ST_E_MUL: begin
        if (mul_rsp.done) begin
          acc_q <= mul_rsp.value;
          j_q   <= j_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign answer_o     = answer_q;
  assign components_o = comps_q;

  // ---------------------------------------------------------------- assertions
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_mul_wait_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.busy |-> (state_q == ufcc_pkg::ST_P_MUL || state_q == ufcc_pkg::ST_E_MUL))
    else $error("multiplier busy outside a wait state");

  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ufcc_pkg::ST_CLEAR) |-> !in_ready_o)
    else $error("input taken during clearing pass");

endmodule

>>> dv/tb_union_find_connect_count_unit.sv
// Self-checking testbench for union_find_connect_count_unit.
// Depends on ufcc_pkg (register indexes) and the DUT; a local forest model predicts each finish.
`timescale 1ns / 1ps

module tb_union_find_connect_count_unit;

  localparam int  MAX_NODES = 1024;
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam int  SETTLE     = 200;      // covers an edge in flight after the last transfer
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct {
    logic [31:0] answer;
    logic [10:0] components;
  } tally_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [10:0] end_a_i;
  logic [10:0] end_b_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] answer_o;
  logic [10:0] components_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  union_find_connect_count_unit #(.MAX_NODES(MAX_NODES)) DUT (.*);

  // Forest model and its copy of the registers.
  int unsigned node_count_q;
  logic [31:0] modulus_q;
  int          link_q [MAX_NODES];
  int          rank_q [MAX_NODES];
  int          size_q [MAX_NODES];

  tally_t      pending_tallies [$];
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          items_sent;
  bit          failed;
  longint      cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("union_find_connect_count_unit regression: fail");
      $finish;
    end
  end

  function automatic void clear_forest();
    for (int i = 0; i < MAX_NODES; i++) begin
      link_q[i] = i;
      rank_q[i] = 0;
      size_q[i] = 0;
    end
  endfunction

  function automatic int root_of_node(int x);
    int r;
    int nxt;
    r = x;
    while (link_q[r] != r) r = link_q[r];
    while (link_q[x] != r) begin
      nxt = link_q[x];
      link_q[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  function automatic longint unsigned reduce_mod(longint unsigned v);
    if (modulus_q == 32'd0) return v & 64'hFFFF_FFFF;
    return v % modulus_q;
  endfunction

  // Apply one transfer to the forest; a finish pushes its expected tally.
  function automatic void apply_item(logic op, logic [10:0] a, logic [10:0] b);
    int unsigned n;
    int ra;
    int rb;
    int k;
    longint unsigned acc;
    tally_t t;
    n = (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
    if (op == OP_EDGE) begin
      if (a >= 1 && b >= 1 && a <= n && b <= n) begin
        ra = root_of_node(a - 1);
        rb = root_of_node(b - 1);
        if (ra != rb) begin
          if (rank_q[ra] >= rank_q[rb]) begin
            link_q[rb] = ra;
            if (rank_q[ra] == rank_q[rb] && rank_q[ra] < 15) rank_q[ra]++;
          end else begin
            link_q[ra] = rb;
          end
        end
      end
      return;
    end
    for (int i = 0; i < n; i++) size_q[root_of_node(i)]++;
    acc = reduce_mod(1);
    k = 0;
    for (int i = 0; i < n; i++) begin
      if (root_of_node(i) == i) begin
        acc = reduce_mod(acc * size_q[i]);
        k++;
      end
    end
    if (k == 1) acc = reduce_mod(1);
    else for (int i = 2; i < k; i++) acc = reduce_mod(acc * n);
    t.answer = acc[31:0];
    t.components = k[10:0];
    pending_tallies.push_back(t);
    clear_forest();
  endfunction

  // Send one item after an optional random gap; valid stays high afterwards.
  task automatic send_item(logic op, logic [10:0] a, logic [10:0] b);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    end_a_i    <= a;
    end_b_i    <= b;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(op, a, b);
    items_sent++;
  endtask

  // Drop valid, then hold until every expected tally has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Two-phase register write; call only after drain.
  task automatic write_reg(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ufcc_pkg::REG_NODE_COUNT) node_count_q = value & 32'h7FF;
    else modulus_q = value;
  endtask

  task automatic finish_forest();
    send_item(OP_FINISH, 11'($urandom), 11'($urandom));
  endtask

  // Full-size forest at reset values: extreme and ignored endpoints.
  task automatic test_edge_extremes();
    send_item(OP_EDGE, 11'd1, 11'd1024);
    send_item(OP_EDGE, 11'd1024, 11'd1);
    send_item(OP_EDGE, 11'd0, 11'd5);
    send_item(OP_EDGE, 11'd5, 11'd0);
    send_item(OP_EDGE, 11'd2047, 11'd3);
    send_item(OP_EDGE, 11'd1025, 11'd2);
    send_item(OP_EDGE, 11'd7, 11'd7);
    send_item(OP_FINISH, 11'd2047, 11'd0);
    drain();
  endtask

  // One, zero and two nodes, then three nodes with a single edge.
  task automatic test_tiny_forests();
    write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd1);
    send_item(OP_EDGE, 11'd1, 11'd1);
    finish_forest();
    drain();
    write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd0);
    send_item(OP_EDGE, 11'd1, 11'd1);
    finish_forest();
    drain();
    write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd2);
    finish_forest();
    drain();
    write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd3);
    send_item(OP_EDGE, 11'd1, 11'd2);
    finish_forest();
    drain();
  endtask

  // Modulus of one, of zero (wraps at 32 bits) and all ones.
  task automatic test_modulus_corners();
    write_reg(ufcc_pkg::REG_MODULUS, 32'd1);
    write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd5);
    send_item(OP_EDGE, 11'd2, 11'd4);
    finish_forest();
    drain();
    write_reg(ufcc_pkg::REG_MODULUS, 32'd0);
    write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd20);
    send_item(OP_EDGE, 11'd3, 11'd9);
    finish_forest();
    drain();
    write_reg(ufcc_pkg::REG_MODULUS, 32'hFFFF_FFFF);
    send_item(OP_EDGE, 11'd20, 11'd1);
    send_item(OP_EDGE, 11'd19, 11'd2);
    finish_forest();
    drain();
  endtask

  // Shrink node_count with edges already merged, then overrange node_count.
  task automatic test_count_shift();
    write_reg(ufcc_pkg::REG_MODULUS, 32'd1000000007);
    write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd20);
    send_item(OP_EDGE, 11'd15, 11'd20);
    send_item(OP_EDGE, 11'd3, 11'd18);
    send_item(OP_EDGE, 11'd3, 11'd4);
    drain();
    write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd10);
    finish_forest();
    drain();
    write_reg(ufcc_pkg::REG_MODULUS, 32'd0);
    write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd2047);
    send_item(OP_EDGE, 11'd1000, 11'd1024);
    send_item(OP_EDGE, 11'd512, 11'd1);
    finish_forest();
    drain();
  endtask

  // Groups of edges closed by a finish; registers move between groups.
  task automatic random_traffic(int send_pct, int stall_pct, int quota);
    int stop_at;
    int edges;
    int unsigned n;
    sender_idle_pct    = send_pct;
    receiver_stall_pct = stall_pct;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 35) begin
        // Registers move only with nothing in flight.
        drain();
        case ($urandom_range(19))
          0:       write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd0);
          1:       write_reg(ufcc_pkg::REG_NODE_COUNT, 32'd1);
          2, 3:    write_reg(ufcc_pkg::REG_NODE_COUNT, $urandom_range(300, 41));
          default: write_reg(ufcc_pkg::REG_NODE_COUNT, $urandom_range(40, 2));
        endcase
        case ($urandom_range(9))
          0:       write_reg(ufcc_pkg::REG_MODULUS, 32'd0);
          1:       write_reg(ufcc_pkg::REG_MODULUS, 32'hFFFF_FFFF);
          2:       write_reg(ufcc_pkg::REG_MODULUS, $urandom_range(50, 1));
          default: write_reg(ufcc_pkg::REG_MODULUS, $urandom);
        endcase
      end
      n = (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
      edges = $urandom_range(14, 0);
      repeat (edges) begin
        if (n >= 1 && $urandom_range(99) < 85)
          send_item(OP_EDGE, 11'($urandom_range(n, 1)), 11'($urandom_range(n, 1)));
        else
          send_item(OP_EDGE, 11'($urandom), 11'($urandom));
      end
      finish_forest();
      // Now and then hold off until the tally is back.
      if ($urandom_range(3) == 0) drain();
      else if (items_sent >= stop_at) drain();
    end
    drain();
  endtask

  // Receiver: random back-pressure at receiver_stall_pct percent.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Compare each result transfer with the oldest expected tally.
  always @(posedge clk_i) begin
    tally_t exp_t;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t: unexpected result answer=%0d components=%0d",
                 $time, answer_o, components_o);
        failed = 1'b1;
      end else begin
        exp_t = pending_tallies.pop_front();
        if (answer_o !== exp_t.answer) begin
          $display("%0t: answer expected %0d actual %0d", $time, exp_t.answer, answer_o);
          failed = 1'b1;
        end
        if (components_o !== exp_t.components) begin
          $display("%0t: components expected %0d actual %0d",
                   $time, exp_t.components, components_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_EDGE;
    end_a_i     = '0;
    end_b_i     = '0;
    out_ready_i = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cycle_count = 0;
    failed      = 1'b0;
    items_sent  = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    node_count_q = 1024;
    modulus_q    = 32'd1000000007;
    clear_forest();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_extremes();
    test_tiny_forests();
    test_modulus_corners();
    test_count_shift();
    random_traffic(0, 0, 130);
    random_traffic(52, 0, 130);
    random_traffic(0, 52, 130);
    random_traffic(8, 8, 130);

    if (!failed && pending_tallies.size() == 0) begin
      $display("union_find_connect_count_unit regression: pass");
    end else begin
      $display("union_find_connect_count_unit regression: fail");
    end
    $finish;
  end

endmodule
